FILE: src/n64_pkg.sv
// ----------------------------------------------------------------------------
// n64_pkg
// shared types, constants and the icmpv6 to icmpv4 mapping function
// ----------------------------------------------------------------------------
`default_nettype none

package n64_pkg;

  localparam int N64_TABLE_ENTRIES = 64;

  // command codes
  localparam logic CMD_LOAD      = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  // result status codes
  localparam logic [2:0] ST_TRANSLATED = 3'd0;
  localparam logic [2:0] ST_FRAG_DROP  = 3'd1;
  localparam logic [2:0] ST_NO_MAPPING = 3'd2;
  localparam logic [2:0] ST_ICMP_DROP  = 3'd3;
  localparam logic [2:0] ST_STORED     = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  // protocol numbers
  localparam logic [7:0] NH_FRAGMENT = 8'd44;
  localparam logic [7:0] NH_ICMPV6   = 8'd58;
  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [15:0] V4_HDR_BYTES = 16'd20;

  // icmpv6 types
  localparam logic [7:0] ICMP6_UNREACHABLE  = 8'd1;
  localparam logic [7:0] ICMP6_PKT_TOO_BIG  = 8'd2;
  localparam logic [7:0] ICMP6_TIME_EXCEED  = 8'd3;
  localparam logic [7:0] ICMP6_BAD_PARAM    = 8'd4;

  // icmpv6 codes
  localparam logic [7:0] UNREACH_NO_ROUTE   = 8'd0;
  localparam logic [7:0] UNREACH_ADMIN      = 8'd1;
  localparam logic [7:0] UNREACH_SCOPE      = 8'd2;
  localparam logic [7:0] UNREACH_ADDR       = 8'd3;
  localparam logic [7:0] UNREACH_PORT       = 8'd4;
  localparam logic [7:0] PARAM_HEADER_FIELD = 8'd0;
  localparam logic [7:0] PARAM_NEXT_HEADER  = 8'd1;

  // icmpv4 types and codes
  localparam logic [7:0] ICMP_DST_UNREACH   = 8'd3;
  localparam logic [7:0] ICMP_TIME_EXCEED   = 8'd11;
  localparam logic [7:0] ICMP_PARAM_PROB    = 8'd12;
  localparam logic [7:0] ICMP_C_HOST        = 8'd1;
  localparam logic [7:0] ICMP_C_HOST_ADMIN  = 8'd10;
  localparam logic [7:0] ICMP_C_PORT        = 8'd3;
  localparam logic [7:0] ICMP_C_NEED_FRAG   = 8'd4;
  localparam logic [7:0] ICMP_C_PROTO       = 8'd2;
  localparam logic [7:0] ICMP_C_POINTER     = 8'd0;

  typedef struct packed {
    logic start;
    logic scan;
    logic emit;
  } n64_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_busy;
  } n64_stat_t;

  typedef struct packed {
    logic        drop;
    logic [7:0]  itype;
    logic [7:0]  icode;
    logic [31:0] rest;
  } icmp_map_t;

  function automatic icmp_map_t map_icmp(input logic [7:0] itype, input logic [7:0] icode,
                                         input logic [31:0] rest);
    icmp_map_t m;
    m.drop  = 1'b0;
    m.itype = itype;
    m.icode = icode;
    m.rest  = rest;
    case (itype)
      ICMP6_UNREACHABLE: begin
        m.itype = ICMP_DST_UNREACH;
        case (icode)
          UNREACH_NO_ROUTE, UNREACH_SCOPE, UNREACH_ADDR: m.icode = ICMP_C_HOST;
          UNREACH_ADMIN:    m.icode = ICMP_C_HOST_ADMIN;
          UNREACH_PORT:     m.icode = ICMP_C_PORT;
          default:          m.drop  = 1'b1;
        endcase
      end
      ICMP6_PKT_TOO_BIG: begin
        m.itype = ICMP_DST_UNREACH;
        m.icode = ICMP_C_NEED_FRAG;
        m.rest  = {16'h0000, rest[15:0] - V4_HDR_BYTES};
      end
      ICMP6_TIME_EXCEED: begin
        m.itype = ICMP_TIME_EXCEED;
      end
      ICMP6_BAD_PARAM: begin
        case (icode)
          PARAM_HEADER_FIELD: begin
            m.itype = ICMP_PARAM_PROB;
            m.icode = ICMP_C_POINTER;
          end
          PARAM_NEXT_HEADER: begin
            m.itype = ICMP_DST_UNREACH;
            m.icode = ICMP_C_PROTO;
            m.rest  = 32'h0000_0000;
          end
          default: m.drop = 1'b1;
        endcase
      end
      default: begin
        m.drop = 1'b0;
      end
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: src/n64_ctrl.sv
// ----------------------------------------------------------------------------
// n64_ctrl
// request sequencer: accept, table scan, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module n64_ctrl
  import n64_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire n64_stat_t stat,
  output n64_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  property p_emit_only_result;
    @(posedge clk) disable iff (rst) cmd.emit |-> state == S_RESULT && !stat.out_busy;
  endproperty
  a_emit_only_result: assert property (p_emit_only_result)
    else $error("emit outside result state");

  property p_start_to_scan;
    @(posedge clk) disable iff (rst) cmd.start |=> state == S_SCAN;
  endproperty
  a_start_to_scan: assert property (p_start_to_scan)
    else $error("accepted request did not start a scan");

  property p_emit_to_idle;
    @(posedge clk) disable iff (rst) cmd.emit |=> s_tready;
  endproperty
  a_emit_to_idle: assert property (p_emit_to_idle)
    else $error("not ready after result hand-off");

endmodule

`default_nettype wire

FILE: src/n64_datapath.sv
// ----------------------------------------------------------------------------
// n64_datapath
// request register, mapping table memory with sequential key scan,
// header field translation and result register
// ----------------------------------------------------------------------------
`default_nettype none

module n64_datapath
  import n64_pkg::*;
#(
  parameter int TABLE_ENTRIES = N64_TABLE_ENTRIES
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire n64_cmd_t       cmd,
  output n64_stat_t           stat,
  input  wire logic   [0:0]   s_tuser,
  input  wire logic   [247:0] s_tdata,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic        [2:0]   m_tuser,
  output logic        [119:0] m_tdata
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);

  // request register
  logic        req_cmd;
  logic [63:0] req_hi;
  logic [63:0] req_lo;
  logic [31:0] req_a4;
  logic [7:0]  req_tc;
  logic [15:0] req_plen;
  logic [7:0]  req_nh;
  logic [7:0]  req_hop;
  logic [7:0]  req_itype;
  logic [7:0]  req_icode;
  logic [31:0] req_irest;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_cmd   <= s_tuser[0];
      req_hi    <= s_tdata[63:0];
      req_lo    <= s_tdata[127:64];
      req_a4    <= s_tdata[159:128];
      req_tc    <= s_tdata[167:160];
      req_plen  <= s_tdata[183:168];
      req_nh    <= s_tdata[191:184];
      req_hop   <= s_tdata[199:192];
      req_itype <= s_tdata[207:200];
      req_icode <= s_tdata[215:208];
      req_irest <= s_tdata[247:216];
    end
  end

  // mapping table
  logic [63:0] key_high  [TABLE_ENTRIES];
  logic [63:0] key_low   [TABLE_ENTRIES];
  logic [31:0] mapped_v4 [TABLE_ENTRIES];

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] scan_addr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [63:0]      rd_hi;
  logic [63:0]      rd_lo;
  logic [31:0]      rd_v4;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [31:0]      hit_v4;
  logic             issue;

  assign issue = cmd.scan && (scan_addr < entry_count);

  always_ff @(posedge clk) begin
    rd_hi  <= key_high[scan_addr[IDX_W-1:0]];
    rd_lo  <= key_low[scan_addr[IDX_W-1:0]];
    rd_v4  <= mapped_v4[scan_addr[IDX_W-1:0]];
    rd_idx <= scan_addr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
    end else if (cmd.start) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      hit       <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
      if (rd_vld && rd_hi == req_hi && rd_lo == req_lo) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && rd_hi == req_hi && rd_lo == req_lo) begin
      hit_idx <= rd_idx;
      hit_v4  <= rd_v4;
    end
  end

  assign stat.scan_end = (scan_addr >= entry_count) && !rd_vld;
  assign stat.out_busy = m_tvalid && !m_tready;

  // load writes
  logic             new_entry;
  logic             v4_wr;
  logic [IDX_W-1:0] wr_idx;

  assign new_entry = cmd.emit && req_cmd == CMD_LOAD && !hit && entry_count != ENTRIES_C;
  assign v4_wr     = cmd.emit && req_cmd == CMD_LOAD && (hit || entry_count != ENTRIES_C);
  assign wr_idx    = hit ? hit_idx : entry_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (new_entry) begin
      key_high[wr_idx] <= req_hi;
      key_low[wr_idx]  <= req_lo;
    end
    if (v4_wr) begin
      mapped_v4[wr_idx] <= req_a4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (new_entry) begin
      entry_count <= entry_count + CNT_W'(1);
    end
  end

  // result
  icmp_map_t    im;
  logic [2:0]   res_status;
  logic [119:0] res_data;
  logic         is_icmp;

  assign im      = map_icmp(req_itype, req_icode, req_irest);
  assign is_icmp = req_nh == NH_ICMPV6;

  always_comb begin
    res_data = '0;
    if (req_cmd == CMD_LOAD) begin
      res_status = (hit || entry_count != ENTRIES_C) ? ST_STORED : ST_FULL;
    end else if (req_nh == NH_FRAGMENT) begin
      res_status = ST_FRAG_DROP;
    end else if (!hit) begin
      res_status = ST_NO_MAPPING;
    end else if (is_icmp && im.drop) begin
      res_status = ST_ICMP_DROP;
    end else begin
      res_status       = ST_TRANSLATED;
      res_data[31:0]   = hit_v4;
      res_data[39:32]  = req_tc;
      res_data[55:40]  = req_plen + V4_HDR_BYTES;
      res_data[63:56]  = req_hop;
      res_data[71:64]  = is_icmp ? PROTO_ICMP : req_nh;
      if (is_icmp) begin
        res_data[79:72]  = im.itype;
        res_data[87:80]  = im.icode;
        res_data[119:88] = im.rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= res_status;
      m_tdata <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  property p_count_bound;
    @(posedge clk) disable iff (rst) entry_count <= ENTRIES_C;
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("entry count beyond table size");

  property p_emit_valid;
    @(posedge clk) disable iff (rst) cmd.emit |=> m_tvalid;
  endproperty
  a_emit_valid: assert property (p_emit_valid)
    else $error("result not presented after emit");

  property p_emit_scan_idle;
    @(posedge clk) disable iff (rst) cmd.emit |-> !rd_vld && !issue;
  endproperty
  a_emit_scan_idle: assert property (p_emit_scan_idle)
    else $error("result emitted while scan still active");

  property p_grow_by_one;
    @(posedge clk) disable iff (rst) new_entry |=> entry_count == $past(entry_count) + CNT_W'(1);
  endproperty
  a_grow_by_one: assert property (p_grow_by_one)
    else $error("entry count did not advance on new entry");

endmodule

`default_nettype wire

FILE: src/nat64_v6_to_v4_header_translate.sv
// ----------------------------------------------------------------------------
// nat64_v6_to_v4_header_translate
// stateless nat64 ipv6 to ipv4 header translation with exact-match
// source address table
// ----------------------------------------------------------------------------
//  channel   dir  tuser            tdata
//  s_*       in   command          ipv6 header fields and mapping payload
//  m_*       out  status           ipv4 header and icmpv4 fields
//
//  a request steps through accept, a scan of the stored entries in order on
//  the single table read port, a registered table read, a step that sees
//  the scan end, and a result step.
//  reset clears the entry count; the table contents need no clearing.
//  a finished result waits in the output register; the next request is
//  taken meanwhile and holds in its result step until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module nat64_v6_to_v4_header_translate
  import n64_pkg::*;
#(
  parameter int TABLE_ENTRIES = N64_TABLE_ENTRIES
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // command
  input  wire logic [0:0]   s_tuser,
  // addr6_high, addr6_low, addr4, traffic_class, v6_len, next_header,
  // hop_limit, icmp_type, icmp_code, icmp_rest
  input  wire logic [247:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // status
  output logic      [2:0]   m_tuser,
  // source4, type_of_service, v4_len, ttl, protocol,
  // icmp_type_out, icmp_code_out, icmp_rest_out
  output logic      [119:0] m_tdata
);

  n64_cmd_t  cmd;
  n64_stat_t stat;

  n64_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  n64_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire
